// ===== rtl/core/filled_circle_span_rasterizer_top_assert.svh =====
// Assertion macros for the circle span rasterizer checker.
`ifndef FILLED_CIRCLE_SPAN_RASTERIZER_TOP_ASSERT_SVH
`define FILLED_CIRCLE_SPAN_RASTERIZER_TOP_ASSERT_SVH

// Same-cycle implication.
`define FCSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcsr: same-cycle check failed");

// Next-cycle implication.
`define FCSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcsr: next-cycle check failed");

`endif

// ===== rtl/core/fcsr_pkg.sv =====
package fcsr_pkg;

  localparam int unsigned CoordW  = 10;
  localparam int unsigned RadiusW = 5;
  localparam int unsigned ColorW  = 16;
  localparam int unsigned DyW     = RadiusW + 1;
  localparam int unsigned SqW     = 2 * RadiusW;
  localparam int unsigned PosW    = CoordW + 2;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_WALK
  } fcsr_state_e;

  typedef struct packed {
    logic load;
    logic adjust;
    logic emit;
  } fcsr_cmd_t;

  typedef struct packed {
    logic adj_needed;
    logic last_row;
  } fcsr_status_t;

endpackage

// ===== rtl/core/fcsr_ctrl.sv =====
module fcsr_ctrl
  import fcsr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  fcsr_status_t status_i,
  output fcsr_cmd_t    cmd_o
);

  fcsr_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (cmd_o.emit && status_i.last_row) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_WALK: begin
        cmd_o.adjust = status_i.adj_needed;
        cmd_o.emit   = !status_i.adj_needed && out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/fcsr_datapath.sv =====
module fcsr_datapath
  import fcsr_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 280,
  parameter int unsigned MAX_RADIUS    = 31
) (
  input  logic                clk_i,
  input  fcsr_cmd_t           cmd_i,
  output fcsr_status_t        status_o,
  input  logic [CoordW-1:0]   center_x_i,
  input  logic [CoordW-1:0]   center_y_i,
  input  logic [RadiusW-1:0]  circle_radius_i,
  input  logic [ColorW-1:0]   fill_color_i,
  output logic [CoordW-1:0]   screen_row_o,
  output logic [CoordW-1:0]   span_col_low_o,
  output logic [CoordW-1:0]   span_col_high_o,
  output logic [ColorW-1:0]   span_color_o,
  output logic                span_empty_o,
  output logic                last_row_o
);

  localparam logic [RadiusW-1:0]     MaxR   = RadiusW'(MAX_RADIUS);
  localparam logic signed [PosW-1:0] ScrW   = PosW'(SCREEN_WIDTH);
  localparam logic signed [PosW-1:0] ScrH   = PosW'(SCREEN_HEIGHT);
  localparam logic signed [PosW-1:0] PosOne = PosW'(1);

  logic [CoordW-1:0]        cx_q, cy_q;
  logic [RadiusW-1:0]       r_q;
  logic [SqW-1:0]           r_sq_q;
  logic [ColorW-1:0]        color_q;
  logic signed [DyW-1:0]    dy_q;
  logic [RadiusW-1:0]       h_q;

  logic [RadiusW-1:0]       r_sat;
  logic [RadiusW-1:0]       dy_abs;
  logic [SqW-1:0]           dy_sq;
  logic [SqW-1:0]           lim;
  logic [SqW-1:0]           h_sq;
  logic [RadiusW:0]         h_inc;
  logic [SqW:0]             h_inc_sq;
  logic                     grow;
  logic                     shrink;

  logic signed [PosW-1:0]   y_pos, xl, xh, xl_c, xh_c;
  logic                     empty;

  logic [CoordW-1:0]        row_q, low_q, high_q;
  logic [ColorW-1:0]        ocolor_q;
  logic                     oempty_q, olast_q;

  assign r_sat    = (circle_radius_i > MaxR) ? MaxR : circle_radius_i;
  assign dy_abs   = dy_q[DyW-1] ? RadiusW'(-dy_q) : dy_q[RadiusW-1:0];
  assign dy_sq    = SqW'(dy_abs * dy_abs);
  assign lim      = r_sq_q - dy_sq;
  assign h_sq     = SqW'(h_q * h_q);
  assign h_inc    = {1'b0, h_q} + (RadiusW+1)'(1);
  assign h_inc_sq = (SqW+1)'(h_inc * h_inc);
  assign grow     = h_inc_sq <= {1'b0, lim};
  assign shrink   = h_sq > lim;

  assign status_o.adj_needed = grow || shrink;
  assign status_o.last_row   = dy_q == $signed({1'b0, r_q});

  assign y_pos = $signed({2'b00, cy_q}) + PosW'(dy_q);
  assign xl    = $signed({2'b00, cx_q}) - $signed(PosW'(h_q));
  assign xh    = $signed({2'b00, cx_q}) + $signed(PosW'(h_q));
  assign xl_c  = (xl < PosOne) ? PosOne : xl;
  assign xh_c  = (xh > ScrW - PosOne) ? ScrW - PosOne : xh;
  assign empty = (y_pos < PosOne) || (y_pos > ScrH - PosOne) || (xl_c > xh_c);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q    <= center_x_i;
      cy_q    <= center_y_i;
      r_q     <= r_sat;
      r_sq_q  <= SqW'(r_sat * r_sat);
      color_q <= fill_color_i;
      dy_q    <= -$signed({1'b0, r_sat});
      h_q     <= '0;
    end else if (cmd_i.adjust) begin
      h_q <= grow ? h_q + RadiusW'(1) : h_q - RadiusW'(1);
    end else if (cmd_i.emit) begin
      dy_q <= dy_q + DyW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      olast_q  <= status_o.last_row;
      oempty_q <= empty;
      if (empty) begin
        row_q    <= '0;
        low_q    <= '0;
        high_q   <= '0;
        ocolor_q <= '0;
      end else begin
        row_q    <= CoordW'(ScrH - y_pos);
        low_q    <= CoordW'(ScrW - xh_c);
        high_q   <= CoordW'(ScrW - xl_c);
        ocolor_q <= color_q;
      end
    end
  end

  assign screen_row_o    = row_q;
  assign span_col_low_o  = low_q;
  assign span_col_high_o = high_q;
  assign span_color_o    = ocolor_q;
  assign span_empty_o    = oempty_q;
  assign last_row_o      = olast_q;

endmodule

// ===== rtl/core/filled_circle_span_rasterizer_top.sv =====
// Filled circle span rasterizer: each accepted draw request (center, radius, color) yields
// 2*r+1 span transactions, one per row from top offset -r to +r, with last_row set on the
// final one; a radius above MAX_RADIUS is saturated. Spans are clipped to columns
// 1..SCREEN_WIDTH-1 and rows 1..SCREEN_HEIGHT-1 and mirrored; a fully clipped row comes out
// with span_empty set and its row, column and color fields zero. The half-width is tracked
// by a single step-by-one register, so a request passes through an accept step, one emit
// step per row and one adjust step per unit change of the half-width, with emits held while
// the output is stalled; the next request is taken once the last row is in the output register.
module filled_circle_span_rasterizer_top
  import fcsr_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 280,
  parameter int unsigned MAX_RADIUS    = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CoordW-1:0]   center_x_i,
  input  logic [CoordW-1:0]   center_y_i,
  input  logic [RadiusW-1:0]  circle_radius_i,
  input  logic [ColorW-1:0]   fill_color_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CoordW-1:0]   screen_row_o,
  output logic [CoordW-1:0]   span_col_low_o,
  output logic [CoordW-1:0]   span_col_high_o,
  output logic [ColorW-1:0]   span_color_o,
  output logic                span_empty_o,
  output logic                last_row_o
);

  fcsr_cmd_t    cmd;
  fcsr_status_t status;

  fcsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fcsr_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MAX_RADIUS    (MAX_RADIUS)
  ) u_datapath (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .circle_radius_i (circle_radius_i),
    .fill_color_i    (fill_color_i),
    .screen_row_o    (screen_row_o),
    .span_col_low_o  (span_col_low_o),
    .span_col_high_o (span_col_high_o),
    .span_color_o    (span_color_o),
    .span_empty_o    (span_empty_o),
    .last_row_o      (last_row_o)
  );

endmodule

// ===== rtl/core/fcsr_checker.sv =====
`include "filled_circle_span_rasterizer_top_assert.svh"

module fcsr_checker
  import fcsr_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 280
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [CoordW-1:0]   screen_row_o,
  input logic [CoordW-1:0]   span_col_low_o,
  input logic [CoordW-1:0]   span_col_high_o,
  input logic [ColorW-1:0]   span_color_o,
  input logic                span_empty_o,
  input logic                last_row_o
);

  localparam logic [CoordW-1:0] MaxCol = CoordW'(SCREEN_WIDTH - 1);
  localparam logic [CoordW-1:0] MaxRow = CoordW'(SCREEN_HEIGHT - 1);

  // Hold a stalled transaction.
  `FCSR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(screen_row_o) && $stable(span_col_low_o) && $stable(span_col_high_o) && $stable(span_color_o) && $stable(span_empty_o) && $stable(last_row_o))

  `FCSR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  `FCSR_ASSERT_NOW(a_empty_zero, out_valid_o && span_empty_o, screen_row_o == '0 && span_col_low_o == '0 && span_col_high_o == '0 && span_color_o == '0)

  `FCSR_ASSERT_NOW(a_span_in_screen, out_valid_o && !span_empty_o, screen_row_o != '0 && screen_row_o <= MaxRow && span_col_low_o != '0 && span_col_low_o <= span_col_high_o && span_col_high_o <= MaxCol)

endmodule

bind filled_circle_span_rasterizer_top fcsr_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_fcsr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .screen_row_o    (screen_row_o),
  .span_col_low_o  (span_col_low_o),
  .span_col_high_o (span_col_high_o),
  .span_color_o    (span_color_o),
  .span_empty_o    (span_empty_o),
  .last_row_o      (last_row_o)
);
